// ----- rtl/box_average_downsampler_macros.svh -----
// Assertion helpers for the downsampler RTL.
`ifndef BOX_AVERAGE_DOWNSAMPLER_MACROS_SVH
`define BOX_AVERAGE_DOWNSAMPLER_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define BXA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define BXA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BXA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define BXA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ----- rtl/bxa_pkg.sv -----
package bxa_pkg;

  localparam int MAX_COLS   = 1024;
  localparam int MAX_FACTOR = 16;
  localparam int MAX_ROWS   = 4096;

  localparam int PIX_W  = 8;
  localparam int ROW_W  = 12;
  localparam int COL_W  = $clog2(MAX_COLS);
  localparam int SUM_W  = 16;
  localparam int FAC_W  = 5;
  localparam int ROWS_W = 13;
  localparam int COLS_W = 11;
  localparam int CFG_W  = 13;
  localparam int PH_W   = $clog2(MAX_FACTOR);

  // divider operand widths
  localparam int DIV_N   = 16;
  localparam int DVS_W   = 9;
  localparam int DCNT_W  = $clog2(DIV_N + 1);

  // configuration register indexes
  localparam logic [1:0] CFG_IDX_FACTOR = 2'd0;
  localparam logic [1:0] CFG_IDX_ROWS   = 2'd1;
  localparam logic [1:0] CFG_IDX_COLS   = 2'd2;

  // per-pixel control decided at acceptance
  typedef struct packed {
    logic use_pix;
    logic row_first;
    logic row_last;
    logic col_first;
    logic emit;
  } bxa_ctl_t;

  // output position carried with a block
  typedef struct packed {
    logic             frame_last;
    logic [ROW_W-1:0] blk_row;
    logic [COL_W-1:0] blk_col;
  } bxa_pos_t;

endpackage

// ----- rtl/bxa_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
module bxa_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [bxa_pkg::DIV_N-1:0]  dividend,
  input  logic [bxa_pkg::DVS_W-1:0]  divisor,
  output logic                       busy,
  output logic                       done,
  output logic [bxa_pkg::DIV_N-1:0]  quotient,
  output logic [bxa_pkg::DVS_W-1:0]  remainder
);

  logic [bxa_pkg::DIV_N-1:0]  quo_r;
  logic [bxa_pkg::DVS_W-1:0]  rem_r;
  logic [bxa_pkg::DVS_W-1:0]  dvs_r;
  logic [bxa_pkg::DCNT_W-1:0] cnt_r;
  logic                       busy_r;
  logic                       done_r;
  logic [bxa_pkg::DVS_W:0]    trial;
  logic                       fits;

  assign trial = {rem_r, quo_r[bxa_pkg::DIV_N-1]};
  assign fits  = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= bxa_pkg::DCNT_W'(bxa_pkg::DIV_N);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == bxa_pkg::DCNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[bxa_pkg::DIV_N-2:0], fits};
      rem_r <= fits ? bxa_pkg::DVS_W'(trial - {1'b0, dvs_r})
                    : trial[bxa_pkg::DVS_W-1:0];
    end
  end

  assign busy      = busy_r;
  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

// ----- rtl/bxa_line.sv -----
// Line store of column sums with read-modify-write and the block accumulator.
module bxa_line (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_fire,
  input  logic [bxa_pkg::COL_W-1:0]       rd_col,
  input  logic signed [bxa_pkg::PIX_W-1:0] pix,
  input  bxa_pkg::bxa_ctl_t               ctl,
  input  bxa_pkg::bxa_pos_t               pos_in,
  output logic                            emit,
  output logic signed [bxa_pkg::SUM_W-1:0] block_sum,
  output bxa_pkg::bxa_pos_t               pos_out
);

  logic [bxa_pkg::SUM_W-1:0] mem [bxa_pkg::MAX_COLS];

  logic [bxa_pkg::SUM_W-1:0]         rd_data_r;
  logic                              s1_valid_r;
  bxa_pkg::bxa_ctl_t                 s1_ctl_r;
  bxa_pkg::bxa_pos_t                 s1_pos_r;
  logic [bxa_pkg::COL_W-1:0]         s1_col_r;
  logic signed [bxa_pkg::PIX_W-1:0]  s1_pix_r;

  logic                              wr_en;
  logic                              last_wr_en_r;
  logic [bxa_pkg::COL_W-1:0]         last_wr_col_r;
  logic [bxa_pkg::SUM_W-1:0]         last_wr_data_r;

  logic signed [bxa_pkg::SUM_W-1:0]  acc_r;
  logic signed [bxa_pkg::SUM_W-1:0]  acc_nxt;
  logic signed [bxa_pkg::SUM_W-1:0]  base;
  logic signed [bxa_pkg::SUM_W-1:0]  pix_ext;
  logic signed [bxa_pkg::SUM_W-1:0]  vsum;

  // read issued as the pixel is accepted
  always_ff @(posedge clk) begin
    if (in_fire) begin
      rd_data_r <= mem[rd_col];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[s1_col_r] <= vsum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      last_wr_en_r <= 1'b0;
      acc_r        <= '0;
    end else begin
      s1_valid_r   <= in_fire;
      last_wr_en_r <= wr_en;
      acc_r        <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_ctl_r <= ctl;
      s1_pos_r <= pos_in;
      s1_col_r <= rd_col;
      s1_pix_r <= pix;
    end
    last_wr_col_r  <= s1_col_r;
    last_wr_data_r <= vsum;
  end

  // a write landing on the edge of our read is forwarded
  always_comb begin
    pix_ext = bxa_pkg::SUM_W'(s1_pix_r);
    if (last_wr_en_r && last_wr_col_r == s1_col_r) begin
      base = last_wr_data_r;
    end else begin
      base = rd_data_r;
    end
    vsum    = s1_ctl_r.row_first ? pix_ext : base + pix_ext;
    wr_en   = s1_valid_r && s1_ctl_r.use_pix && !s1_ctl_r.row_last;
    acc_nxt = acc_r;
    if (s1_valid_r && s1_ctl_r.use_pix && s1_ctl_r.row_last) begin
      acc_nxt = s1_ctl_r.col_first ? vsum : acc_r + vsum;
    end
  end

  assign emit      = s1_valid_r && s1_ctl_r.emit;
  assign block_sum = acc_nxt;
  assign pos_out   = s1_pos_r;

endmodule

// ----- rtl/box_average_downsampler.sv -----
// Box-average downscaler. Signed 8-bit pixels arrive in raster order; each
// scale_factor x scale_factor block gives one averaged pixel (truncated
// toward zero) with its block row, block column and a last-of-frame flag.
// Edges shorter than the factor form a single, smaller block; trailing rows
// and columns outside whole blocks are skipped. Rate: a pixel that does not
// close a block is taken every cycle. A pixel that closes a block is taken
// only once the 16-step serial divider that forms the average is idle and
// its last result has moved on into the output register. A configuration
// write holds in_ready low while two serial division passes rebuild the
// block counters from the raster position. Column sums live in a 1024 x 16
// single-port-write line store with a registered read; the store has no
// clearing pass and needs none for whole frames.
`include "box_average_downsampler_macros.svh"

module box_average_downsampler (
  input  logic                              clk,
  input  logic                              rst_n,
  // pixel requests
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [bxa_pkg::PIX_W-1:0]  in_pixel_value,
  // result requests
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [bxa_pkg::PIX_W-1:0]  out_average_value,
  output logic [bxa_pkg::ROW_W-1:0]         out_row,
  output logic [bxa_pkg::COL_W-1:0]         out_col,
  output logic                              out_frame_last,
  // configuration
  input  logic                              cfg_we,
  input  logic [1:0]                        cfg_index,
  input  logic [bxa_pkg::CFG_W-1:0]         cfg_data
);

  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_START_A = 5'b00010,
    ST_WAIT_A  = 5'b00100,
    ST_START_B = 5'b01000,
    ST_WAIT_B  = 5'b10000
  } geo_st_t;

  geo_st_t st_r, st_nxt;

  // configuration registers
  logic [bxa_pkg::FAC_W-1:0]  factor_r;
  logic [bxa_pkg::ROWS_W-1:0] rows_r;
  logic [bxa_pkg::COLS_W-1:0] cols_r;

  // clamped geometry
  logic [bxa_pkg::FAC_W-1:0]  fac_eff;
  logic [bxa_pkg::ROWS_W-1:0] rows_eff;
  logic [bxa_pkg::COLS_W-1:0] cols_eff;
  logic [bxa_pkg::FAC_W-1:0]  vc;
  logic [bxa_pkg::FAC_W-1:0]  hc;
  logic [2*bxa_pkg::FAC_W-1:0] blk_area;

  // raster position and block counters
  logic [bxa_pkg::ROW_W-1:0]  row_r;
  logic [bxa_pkg::COL_W-1:0]  col_r;
  logic [bxa_pkg::PH_W-1:0]   rr_r;
  logic [bxa_pkg::PH_W-1:0]   cc_r;
  logic [bxa_pkg::ROW_W-1:0]  br_r;
  logic [bxa_pkg::COL_W-1:0]  bc_r;
  logic [bxa_pkg::ROWS_W-1:0] nbr_r;
  logic [bxa_pkg::COLS_W-1:0] nbc_r;

  logic                       in_fire;
  logic                       row_last0;
  logic                       col_last0;
  logic [bxa_pkg::COLS_W-1:0] col_inc;
  logic [bxa_pkg::ROWS_W-1:0] row_inc;
  bxa_pkg::bxa_ctl_t          ctl0;
  bxa_pkg::bxa_pos_t          pos0;

  // line store stage
  logic                             line_emit;
  logic signed [bxa_pkg::SUM_W-1:0] line_sum;
  bxa_pkg::bxa_pos_t                line_pos;
  logic [bxa_pkg::SUM_W:0]          sum_ext;
  logic [bxa_pkg::SUM_W:0]          sum_mag;

  // average divider and pending result
  logic                       avg_busy;
  logic                       avg_done;
  logic [bxa_pkg::DIV_N-1:0]  avg_quo;
  logic [bxa_pkg::DVS_W-1:0]  avg_rem;
  logic                       res_ready_r;
  logic                       pend_neg_r;
  bxa_pkg::bxa_pos_t          pend_pos_r;
  logic                       res_move;
  logic [bxa_pkg::PIX_W-1:0]  avg_mag;

  // geometry dividers
  logic                       geo_start;
  logic [bxa_pkg::DIV_N-1:0]  row_dvd;
  logic [bxa_pkg::DIV_N-1:0]  col_dvd;
  logic                       row_busy;
  logic                       col_busy;
  logic                       row_done;
  logic                       col_done;
  logic [bxa_pkg::DIV_N-1:0]  row_quo;
  logic [bxa_pkg::DIV_N-1:0]  col_quo;
  logic [bxa_pkg::DVS_W-1:0]  row_rem;
  logic [bxa_pkg::DVS_W-1:0]  col_rem;

  // output register
  logic                             out_valid_r;
  logic [bxa_pkg::PIX_W-1:0]        out_avg_r;
  bxa_pkg::bxa_pos_t                out_pos_r;

  // ---------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      factor_r <= bxa_pkg::FAC_W'(2);
      rows_r   <= bxa_pkg::ROWS_W'(1);
      cols_r   <= bxa_pkg::COLS_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        bxa_pkg::CFG_IDX_FACTOR: factor_r <= cfg_data[bxa_pkg::FAC_W-1:0];
        bxa_pkg::CFG_IDX_ROWS:   rows_r   <= cfg_data[bxa_pkg::ROWS_W-1:0];
        bxa_pkg::CFG_IDX_COLS:   cols_r   <= cfg_data[bxa_pkg::COLS_W-1:0];
        default: ;
      endcase
    end
  end

  // zero acts as one, oversize values saturate
  always_comb begin
    if (factor_r == '0) begin
      fac_eff = bxa_pkg::FAC_W'(1);
    end else if (factor_r > bxa_pkg::FAC_W'(bxa_pkg::MAX_FACTOR)) begin
      fac_eff = bxa_pkg::FAC_W'(bxa_pkg::MAX_FACTOR);
    end else begin
      fac_eff = factor_r;
    end
    if (rows_r == '0) begin
      rows_eff = bxa_pkg::ROWS_W'(1);
    end else if (rows_r > bxa_pkg::ROWS_W'(bxa_pkg::MAX_ROWS)) begin
      rows_eff = bxa_pkg::ROWS_W'(bxa_pkg::MAX_ROWS);
    end else begin
      rows_eff = rows_r;
    end
    if (cols_r == '0) begin
      cols_eff = bxa_pkg::COLS_W'(1);
    end else if (cols_r > bxa_pkg::COLS_W'(bxa_pkg::MAX_COLS)) begin
      cols_eff = bxa_pkg::COLS_W'(bxa_pkg::MAX_COLS);
    end else begin
      cols_eff = cols_r;
    end
    // short edges make a single, smaller block
    vc = (rows_eff < bxa_pkg::ROWS_W'(fac_eff)) ? rows_eff[bxa_pkg::FAC_W-1:0] : fac_eff;
    hc = (cols_eff < bxa_pkg::COLS_W'(fac_eff)) ? cols_eff[bxa_pkg::FAC_W-1:0] : fac_eff;
    blk_area = {{bxa_pkg::FAC_W{1'b0}}, vc} * {{bxa_pkg::FAC_W{1'b0}}, hc};
  end

  // ---------------------------------------------------------------
  // Acceptance and raster counters
  // ---------------------------------------------------------------
  // a block-closing pixel waits until the average path is free
  assign in_ready = (st_r == ST_IDLE) && !cfg_we &&
                    !(ctl0.emit && (line_emit || avg_busy || avg_done || res_ready_r));
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    row_last0      = ({1'b0, rr_r} == vc - 1'b1);
    col_last0      = ({1'b0, cc_r} == hc - 1'b1);
    ctl0.use_pix   = ({1'b0, br_r} < nbr_r) && ({1'b0, bc_r} < nbc_r);
    ctl0.row_first = (rr_r == '0);
    ctl0.row_last  = row_last0;
    ctl0.col_first = (cc_r == '0);
    ctl0.emit      = ctl0.use_pix && row_last0 && col_last0;
    pos0.frame_last = ctl0.emit &&
                      ({1'b0, br_r} == nbr_r - 1'b1) &&
                      ({1'b0, bc_r} == nbc_r - 1'b1);
    pos0.blk_row   = br_r;
    pos0.blk_col   = bc_r;
    col_inc        = {1'b0, col_r} + 1'b1;
    row_inc        = {1'b0, row_r} + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
      rr_r  <= '0;
      cc_r  <= '0;
      br_r  <= '0;
      bc_r  <= '0;
      nbr_r <= bxa_pkg::ROWS_W'(1);
      nbc_r <= bxa_pkg::COLS_W'(1);
    end else if (in_fire) begin
      if (col_inc >= cols_eff) begin
        col_r <= '0;
        cc_r  <= '0;
        bc_r  <= '0;
        if (row_inc >= rows_eff) begin
          row_r <= '0;
          rr_r  <= '0;
          br_r  <= '0;
        end else begin
          row_r <= row_inc[bxa_pkg::ROW_W-1:0];
          if (row_last0) begin
            rr_r <= '0;
            br_r <= br_r + 1'b1;
          end else begin
            rr_r <= rr_r + 1'b1;
          end
        end
      end else begin
        col_r <= col_inc[bxa_pkg::COL_W-1:0];
        if (col_last0) begin
          cc_r <= '0;
          bc_r <= bc_r + 1'b1;
        end else begin
          cc_r <= cc_r + 1'b1;
        end
      end
    end else if (st_r == ST_WAIT_A && row_done) begin
      nbr_r <= row_quo[bxa_pkg::ROWS_W-1:0];
      nbc_r <= col_quo[bxa_pkg::COLS_W-1:0];
    end else if (st_r == ST_WAIT_B && row_done) begin
      br_r <= row_quo[bxa_pkg::ROW_W-1:0];
      rr_r <= row_rem[bxa_pkg::PH_W-1:0];
      bc_r <= col_quo[bxa_pkg::COL_W-1:0];
      cc_r <= col_rem[bxa_pkg::PH_W-1:0];
    end
  end

  // ---------------------------------------------------------------
  // Geometry rebuild after a configuration write:
  // pass A gives block counts, pass B the position within blocks.
  // ---------------------------------------------------------------
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE:    st_nxt = ST_IDLE;
      ST_START_A: st_nxt = ST_WAIT_A;
      ST_WAIT_A:  if (row_done) st_nxt = ST_START_B;
      ST_START_B: st_nxt = ST_WAIT_B;
      ST_WAIT_B:  if (row_done) st_nxt = ST_IDLE;
      default:    st_nxt = ST_IDLE;
    endcase
    if (cfg_we) begin
      st_nxt = ST_START_A;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  assign geo_start = (st_r == ST_START_A) || (st_r == ST_START_B);
  assign row_dvd = (st_r == ST_START_A) ? bxa_pkg::DIV_N'(rows_eff) : bxa_pkg::DIV_N'(row_r);
  assign col_dvd = (st_r == ST_START_A) ? bxa_pkg::DIV_N'(cols_eff) : bxa_pkg::DIV_N'(col_r);

  bxa_div u_row_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (geo_start),
    .dividend  (row_dvd),
    .divisor   (bxa_pkg::DVS_W'(vc)),
    .busy      (row_busy),
    .done      (row_done),
    .quotient  (row_quo),
    .remainder (row_rem)
  );

  bxa_div u_col_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (geo_start),
    .dividend  (col_dvd),
    .divisor   (bxa_pkg::DVS_W'(hc)),
    .busy      (col_busy),
    .done      (col_done),
    .quotient  (col_quo),
    .remainder (col_rem)
  );

  // ---------------------------------------------------------------
  // Line store and block sums
  // ---------------------------------------------------------------
  bxa_line u_line (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .rd_col    (col_r),
    .pix       (in_pixel_value),
    .ctl       (ctl0),
    .pos_in    (pos0),
    .emit      (line_emit),
    .block_sum (line_sum),
    .pos_out   (line_pos)
  );

  // divide magnitudes, restore the sign afterwards: truncation toward zero
  assign sum_ext = {line_sum[bxa_pkg::SUM_W-1], line_sum};
  assign sum_mag = line_sum[bxa_pkg::SUM_W-1] ? ('0 - sum_ext) : sum_ext;

  bxa_div u_avg_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (line_emit),
    .dividend  (sum_mag[bxa_pkg::DIV_N-1:0]),
    .divisor   (blk_area[bxa_pkg::DVS_W-1:0]),
    .busy      (avg_busy),
    .done      (avg_done),
    .quotient  (avg_quo),
    .remainder (avg_rem)
  );

  always_ff @(posedge clk) begin
    if (line_emit) begin
      pend_neg_r <= line_sum[bxa_pkg::SUM_W-1];
      pend_pos_r <= line_pos;
    end
  end

  // ---------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------
  assign res_move = res_ready_r && (!out_valid_r || out_ready);
  assign avg_mag  = avg_quo[bxa_pkg::PIX_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_ready_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (avg_done) begin
        res_ready_r <= 1'b1;
      end else if (res_move) begin
        res_ready_r <= 1'b0;
      end
      if (res_move) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_move) begin
      out_avg_r <= pend_neg_r ? ('0 - avg_mag) : avg_mag;
      out_pos_r <= pend_pos_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_average_value = out_avg_r;
  assign out_row           = out_pos_r.blk_row;
  assign out_col           = out_pos_r.blk_col;
  assign out_frame_last    = out_pos_r.frame_last;

  // ---------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------
  `BXA_ASSERT_IMPL(a_geo_div_lockstep, clk, rst_n, row_done || col_done,
                   row_done && col_done && !row_busy && !col_busy,
                   "geometry dividers out of step")
  `BXA_ASSERT_IMPL(a_no_pixel_in_rebuild, clk, rst_n, in_fire,
                   st_r == ST_IDLE && !row_busy,
                   "pixel accepted during geometry rebuild")
  `BXA_ASSERT_IMPL(a_avg_path_free, clk, rst_n, line_emit,
                   !avg_busy && !avg_done && !res_ready_r,
                   "block average started over a pending result")
  `BXA_ASSERT_NEXT(a_move_shows, clk, rst_n, res_move,
                   out_valid && !res_ready_r,
                   "result lost between divider and output register")
  `BXA_ASSERT_IMPL(a_avg_rem_bound, clk, rst_n, avg_done,
                   avg_rem < blk_area[bxa_pkg::DVS_W-1:0],
                   "block average remainder not below the block area")

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps

// Regression bench for the box-average downsampler.
// Pixel requests are fed from a queue by a clocked driver; every accepted
// pixel is folded into a local model of the line store and block
// accumulator. Any block average it produces is queued, and a clocked
// monitor checks each result request against the oldest entry.
// The geometry only changes between whole frames, once the block is idle,
// so no line store value is used before this frame has written it.
module tb_top;

  localparam int RANDOM_ITEMS  = 400;
  // idle time after each test; covers the input stall that follows a
  // configuration write and the wait of a block closing pixel
  localparam int SETTLE_CYCLES = 64;
  localparam int CYCLE_LIMIT   = 2_000_000;

  typedef enum int { FRAME_NOISE, FRAME_FLAT, FRAME_FAINT } frame_kind_t;

  typedef struct packed {
    logic signed [bxa_pkg::PIX_W-1:0] avg;
    logic [bxa_pkg::ROW_W-1:0]        row;
    logic [bxa_pkg::COL_W-1:0]        col;
    logic                             last;
  } block_avg_t;

  logic                             clk            = 1'b0;
  logic                             rst_n          = 1'b0;
  logic                             in_valid       = 1'b0;
  logic                             in_ready;
  logic signed [bxa_pkg::PIX_W-1:0] in_pixel_value = '0;
  logic                             out_valid;
  logic                             out_ready      = 1'b0;
  logic signed [bxa_pkg::PIX_W-1:0] out_average_value;
  logic [bxa_pkg::ROW_W-1:0]        out_row;
  logic [bxa_pkg::COL_W-1:0]        out_col;
  logic                             out_frame_last;
  logic                             cfg_we         = 1'b0;
  logic [1:0]                       cfg_index      = bxa_pkg::CFG_IDX_FACTOR;
  logic [bxa_pkg::CFG_W-1:0]        cfg_data       = '0;

  // shadow of the configuration registers, reset values
  logic [4:0]  cfg_factor = 5'd2;
  logic [12:0] cfg_rows   = 13'd1;
  logic [10:0] cfg_cols   = 11'd1;

  // local model state: per-column partial sums, raster position and the
  // running sum across the current block
  int line_sum [bxa_pkg::MAX_COLS];
  int scan_row  = 0;
  int scan_col  = 0;
  int block_sum = 0;

  logic signed [bxa_pkg::PIX_W-1:0] pixel_q [$];
  block_avg_t                       pending_avgs [$];
  block_avg_t                       want;

  int pushed_pixels   = 0;
  int taken_pixels    = 0;
  int mismatches      = 0;
  int cycle_count     = 0;
  int send_idle_pct   = 0;
  int recv_idle_pct   = 0;
  int send_gap_left   = 0;
  int recv_stall_left = 0;

  box_average_downsampler uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_pixel_value    (in_pixel_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_average_value (out_average_value),
    .out_row           (out_row),
    .out_col           (out_col),
    .out_frame_last    (out_frame_last),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // out-of-range edges and factors saturate to 1 .. hi
  function automatic int clamp_edge(input int v, input int hi);
    return (v < 1) ? 1 : ((v > hi) ? hi : v);
  endfunction

  // Fold one accepted pixel into the model; queue the average when the
  // pixel closes a block. Trailing rows and columns only move the raster.
  function automatic void fold_pixel(input logic signed [bxa_pkg::PIX_W-1:0] pix);
    int f, rows, cols, vc, hc, used_rows, used_cols, vsum, quot;
    block_avg_t res;
    f         = clamp_edge(cfg_factor, bxa_pkg::MAX_FACTOR);
    rows      = clamp_edge(cfg_rows, bxa_pkg::MAX_ROWS);
    cols      = clamp_edge(cfg_cols, bxa_pkg::MAX_COLS);
    // an edge shorter than the factor forms one smaller block
    vc        = (rows < f) ? rows : f;
    hc        = (cols < f) ? cols : f;
    used_rows = (rows / vc) * vc;
    used_cols = (cols / hc) * hc;
    if (scan_row < used_rows && scan_col < used_cols) begin
      vsum = (scan_row % vc == 0) ? int'(pix) : line_sum[scan_col] + int'(pix);
      if (scan_row % vc != vc - 1) begin
        line_sum[scan_col] = vsum;
      end else begin
        block_sum = (scan_col % hc == 0) ? vsum : block_sum + vsum;
        if (scan_col % hc == hc - 1) begin
          // int division truncates toward zero, as the block must
          quot     = block_sum / (vc * hc);
          res.avg  = quot[bxa_pkg::PIX_W-1:0];
          res.row  = bxa_pkg::ROW_W'(scan_row / vc);
          res.col  = bxa_pkg::COL_W'(scan_col / hc);
          res.last = (scan_row == used_rows - 1) && (scan_col == used_cols - 1);
          pending_avgs.push_back(res);
        end
      end
    end
    scan_col++;
    if (scan_col >= cols) begin
      scan_col = 0;
      scan_row++;
      if (scan_row >= rows) begin
        scan_row = 0;
      end
    end
  endfunction

  // Driver: offers the next queued pixel, with random idle bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        fold_pixel(in_pixel_value);
        taken_pixels++;
      end
      if (!in_valid || in_ready) begin
        if (send_gap_left > 0) begin
          send_gap_left--;
          in_valid <= 1'b0;
        end else if (pixel_q.size() == 0) begin
          in_valid <= 1'b0;
        end else if ($urandom_range(0, 99) < send_idle_pct) begin
          send_gap_left = $urandom_range(1, 14) - 1;
          in_valid <= 1'b0;
        end else begin
          in_valid       <= 1'b1;
          in_pixel_value <= pixel_q.pop_front();
        end
      end
    end
  end

  // Monitor: checks each result request, stalls in random bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_avgs.size() == 0) begin
          $error("unexpected result request: average_value %0d row %0d col %0d",
                 out_average_value, out_row, out_col);
          mismatches++;
        end else begin
          want = pending_avgs.pop_front();
          if (out_average_value !== want.avg) begin
            $error("average_value: expected %0d, got %0d", want.avg, out_average_value);
            mismatches++;
          end
          if (out_row !== want.row) begin
            $error("out_row: expected %0d, got %0d", want.row, out_row);
            mismatches++;
          end
          if (out_col !== want.col) begin
            $error("out_col: expected %0d, got %0d", want.col, out_col);
            mismatches++;
          end
          if (out_frame_last !== want.last) begin
            $error("frame_last: expected %0d, got %0d", want.last, out_frame_last);
            mismatches++;
          end
        end
      end
      if (recv_stall_left > 0) begin
        recv_stall_left--;
        out_ready <= 1'b0;
      end else if ($urandom_range(0, 99) < recv_idle_pct) begin
        recv_stall_left = $urandom_range(1, 14) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("box_average_downsampler regression: fail");
      $finish;
    end
  end

  task automatic push_pixel(input logic signed [bxa_pkg::PIX_W-1:0] p);
    pixel_q.push_back(p);
    pushed_pixels++;
  endtask

  // Wait for every pixel to be taken and every average to arrive, then
  // leave the block idle for a while before the next configuration.
  task automatic settle();
    while (taken_pixels != pushed_pixels || pending_avgs.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input int val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[bxa_pkg::CFG_W-1:0];
    case (idx)
      bxa_pkg::CFG_IDX_FACTOR: cfg_factor = val[4:0];
      bxa_pkg::CFG_IDX_ROWS:   cfg_rows   = val[12:0];
      bxa_pkg::CFG_IDX_COLS:   cfg_cols   = val[10:0];
      default: ;
    endcase
  endtask

  task automatic set_geometry(input int f, input int r, input int c);
    write_reg(bxa_pkg::CFG_IDX_FACTOR, f);
    write_reg(bxa_pkg::CFG_IDX_ROWS, r);
    write_reg(bxa_pkg::CFG_IDX_COLS, c);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // one whole frame of the current geometry
  task automatic push_frame(input frame_kind_t kind,
                            input logic signed [bxa_pkg::PIX_W-1:0] level);
    int n;
    n = clamp_edge(cfg_rows, bxa_pkg::MAX_ROWS) * clamp_edge(cfg_cols, bxa_pkg::MAX_COLS);
    for (int i = 0; i < n; i++) begin
      case (kind)
        FRAME_FLAT:  push_pixel(level);
        FRAME_FAINT: push_pixel(bxa_pkg::PIX_W'(int'($urandom_range(0, 3)) - 2));
        default: begin
          if ($urandom_range(0, 15) == 0) begin
            push_pixel($urandom_range(0, 1) ? 8'sd127 : -8'sd128);
          end else begin
            push_pixel(bxa_pkg::PIX_W'($urandom_range(0, 255)));
          end
        end
      endcase
    end
  endtask

  initial begin : stimulus
    int random_pixels;
    int f, r, c, k, n_frames;
    frame_kind_t kind;
    logic signed [bxa_pkg::PIX_W-1:0] level;

    random_pixels = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset geometry: factor 2 on a 1x1 frame, so every pixel is its own block
    push_pixel(8'sd127);
    push_pixel(-8'sd128);
    settle();

    // -3/4 must truncate to zero, not round down to -1
    set_geometry(2, 2, 2);
    push_pixel(-8'sd1);
    push_pixel(-8'sd1);
    push_pixel(-8'sd1);
    push_pixel(8'sd0);
    settle();

    // full-scale blocks, plus a trailing column and a trailing row
    set_geometry(2, 3, 5);
    push_pixel(-8'sd128); push_pixel(-8'sd128); push_pixel(8'sd127);
    push_pixel(8'sd127);  push_pixel(8'sd5);
    push_pixel(-8'sd128); push_pixel(-8'sd128); push_pixel(8'sd127);
    push_pixel(8'sd127);  push_pixel(-8'sd7);
    push_pixel(8'sd1);    push_pixel(8'sd2);    push_pixel(8'sd3);
    push_pixel(8'sd4);    push_pixel(-8'sd5);
    settle();

    // zero factor and columns -> a 5x1 column at factor 1
    send_idle_pct = 10;
    recv_idle_pct = 10;
    set_geometry(0, 5, 0);
    push_frame(FRAME_NOISE, '0);
    settle();

    // oversize factor, zero rows -> one row of 16-wide blocks, 8 trailing
    set_geometry(17, 0, 40);
    push_frame(FRAME_NOISE, '0);
    settle();

    // largest full block, flat at both rails
    set_geometry(16, 16, 16);
    push_frame(FRAME_FLAT, -8'sd128);
    push_frame(FRAME_FLAT, 8'sd127);
    settle();

    // random geometries, mostly small; one to three frames per setting
    while (random_pixels < RANDOM_ITEMS) begin
      if (random_pixels > RANDOM_ITEMS * 4 / 5) begin
        // closing stretch runs flat out on both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else begin
        k = $urandom_range(0, 2);
        send_idle_pct = (k == 0) ? 0 : ((k == 1) ? 10 : 30);
        k = $urandom_range(0, 2);
        recv_idle_pct = (k == 0) ? 0 : ((k == 1) ? 10 : 30);
      end

      k = $urandom_range(0, 9);
      f = (k == 0) ? 0 : ((k == 1) ? $urandom_range(17, 31) :
          ((k == 2) ? 16 : $urandom_range(1, 6)));
      k = $urandom_range(0, 9);
      r = (k == 0) ? 0 : ((k == 1) ? $urandom_range(13, 36) : $urandom_range(1, 12));
      k = $urandom_range(0, 9);
      c = (k == 0) ? 0 : ((k == 1) ? $urandom_range(17, 40) : $urandom_range(1, 16));
      set_geometry(f, r, c);

      n_frames = $urandom_range(1, 3);
      for (int i = 0; i < n_frames; i++) begin
        k = $urandom_range(0, 7);
        kind  = (k == 0) ? FRAME_FLAT : ((k == 1) ? FRAME_FAINT : FRAME_NOISE);
        level = $urandom_range(0, 1) ? 8'sd127 : -8'sd128;
        push_frame(kind, level);
        random_pixels += clamp_edge(r, bxa_pkg::MAX_ROWS) * clamp_edge(c, bxa_pkg::MAX_COLS);
      end
      settle();
    end

    settle();
    if (mismatches == 0 && pending_avgs.size() == 0) begin
      $display("box_average_downsampler regression: pass");
    end else begin
      $display("box_average_downsampler regression: fail");
    end
    $finish;
  end

endmodule
